// ===== rtl/core/salc_pkg.sv =====
// Shared constants, state encoding and control/status types for the cache unit.
`timescale 1ns / 1ps
package salc_pkg;

    localparam int WAYS        = 4;
    localparam int SETS        = 64;
    localparam int BLOCK_BYTES = 64;
    localparam int ADDR_BITS   = 16;

    localparam int WAY_W       = $clog2(WAYS);
    localparam int SET_W       = $clog2(SETS);
    localparam int OFF_W       = $clog2(BLOCK_BYTES);
    localparam int TAG_W       = ADDR_BITS - SET_W - OFF_W;
    localparam int RANK_W      = $clog2(WAYS);
    localparam int BLOCK_WORDS = BLOCK_BYTES / 8;
    localparam int WORD_W      = $clog2(BLOCK_WORDS);
    localparam int LINE_AW     = SET_W + WAY_W + WORD_W;
    localparam int LINE_WORDS  = SETS * WAYS * BLOCK_WORDS;
    localparam int MEM_AW      = ADDR_BITS - 3;
    localparam int MEM_WORDS   = 1 << MEM_AW;
    localparam int ENTRY_W     = TAG_W + RANK_W;
    localparam int SET_ENTRY_W = WAYS * ENTRY_W;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_TAG   = 10'b00_0000_0100,
        S_CMP   = 10'b00_0000_1000,
        S_FILL  = 10'b00_0001_0000,
        S_RD0   = 10'b00_0010_0000,
        S_RD1   = 10'b00_0100_0000,
        S_CAP   = 10'b00_1000_0000,
        S_WR0   = 10'b01_0000_0000,
        S_WR1   = 10'b10_0000_0000
    } state_t;

    typedef struct packed {
        logic              clear;
        logic [MEM_AW-1:0] clr_addr;
        logic              accept;
        logic              cmp;
        logic              fill;
        logic [WORD_W:0]   fill_cnt;
        logic              rd0;
        logic              rd1;
        logic              cap;
        logic              wr0;
        logic              wr1;
    } cmd_t;

    typedef struct packed {
        logic alloc;
        logic hit;
    } status_t;

endpackage

// ===== rtl/core/salc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module salc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/salc_ctrl.sv =====
// Controller state machine: clearing pass, lookup, block transfer and word access phases.
`timescale 1ns / 1ps
module salc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output salc_pkg::cmd_t   cmd,
    input  salc_pkg::status_t status
);

    salc_pkg::state_t                  state_reg, state_next;
    logic [salc_pkg::MEM_AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic [salc_pkg::WORD_W:0]         fill_cnt_reg, fill_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= salc_pkg::S_CLEAR;
            clr_cnt_reg  <= '0;
            fill_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            fill_cnt_reg <= fill_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        fill_cnt_next = fill_cnt_reg;
        unique case (state_reg)
            salc_pkg::S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = salc_pkg::S_IDLE;
                end
            end
            salc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = salc_pkg::S_TAG;
                end
            end
            salc_pkg::S_TAG:
            begin
                state_next = salc_pkg::S_CMP;
            end
            salc_pkg::S_CMP:
            begin
                fill_cnt_next = '0;
                state_next    = status.alloc ? salc_pkg::S_FILL : salc_pkg::S_RD0;
            end
            salc_pkg::S_FILL:
            begin
                fill_cnt_next = fill_cnt_reg + 1'b1;
                if (fill_cnt_reg == (salc_pkg::WORD_W + 1)'(salc_pkg::BLOCK_WORDS))
                begin
                    state_next = salc_pkg::S_RD0;
                end
            end
            salc_pkg::S_RD0: state_next = salc_pkg::S_RD1;
            salc_pkg::S_RD1: state_next = salc_pkg::S_CAP;
            salc_pkg::S_CAP: state_next = salc_pkg::S_WR0;
            salc_pkg::S_WR0: state_next = salc_pkg::S_WR1;
            salc_pkg::S_WR1: state_next = salc_pkg::S_IDLE;
            default:         state_next = salc_pkg::S_IDLE;
        endcase
    end

    assign busy = (state_reg != salc_pkg::S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.clear    = (state_reg == salc_pkg::S_CLEAR);
        cmd.clr_addr = clr_cnt_reg;
        cmd.accept   = (state_reg == salc_pkg::S_IDLE) && start;
        cmd.cmp      = (state_reg == salc_pkg::S_CMP);
        cmd.fill     = (state_reg == salc_pkg::S_FILL);
        cmd.fill_cnt = fill_cnt_reg;
        cmd.rd0      = (state_reg == salc_pkg::S_RD0);
        cmd.rd1      = (state_reg == salc_pkg::S_RD1);
        cmd.cap      = (state_reg == salc_pkg::S_CAP);
        cmd.wr0      = (state_reg == salc_pkg::S_WR0);
        cmd.wr1      = (state_reg == salc_pkg::S_WR1);
    end

endmodule

// ===== rtl/core/salc_datapath.sv =====
// Datapath: tag/LRU store, line and memory RAMs, byte merge and result registers.
`timescale 1ns / 1ps
module salc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  salc_pkg::cmd_t      cmd,
    output salc_pkg::status_t   status,
    input  logic                write_through_we,
    input  logic                write_through,
    input  logic                operation,
    input  logic [15:0]         byte_address,
    input  logic [3:0]          access_bytes,
    input  logic [63:0]         store_data,
    output logic                done,
    output logic                was_store,
    output logic [15:0]         echo_address,
    output logic                hit,
    output logic [63:0]         load_data
);

    localparam int WAYS   = salc_pkg::WAYS;
    localparam int TAG_W  = salc_pkg::TAG_W;
    localparam int RANK_W = salc_pkg::RANK_W;
    localparam int WAY_W  = salc_pkg::WAY_W;
    localparam int SET_W  = salc_pkg::SET_W;
    localparam int OFF_W  = salc_pkg::OFF_W;
    localparam int WORD_W = salc_pkg::WORD_W;
    localparam int ENT_W  = salc_pkg::ENTRY_W;

    // Writes the n access bytes into a two-word window, first byte at position lo.
    function automatic logic [127:0] merge_bytes(input logic [127:0] win, input logic [2:0] lo,
                                                 input logic [3:0] n, input logic [63:0] data);
        logic [127:0] res;
        logic [3:0]   pos;
        logic [2:0]   src;
        res = win;
        for (int i = 0; i < 8; i++)
        begin
            pos = {1'b0, lo} + 4'(i);
            src = 3'(n - 4'(i) - 4'd1);
            if (4'(i) < n)
            begin
                res[pos*8 +: 8] = data[src*8 +: 8];
            end
        end
        return res;
    endfunction

    // Packs the n access bytes of a window, first byte most significant.
    function automatic logic [63:0] extract_bytes(input logic [127:0] win, input logic [2:0] lo,
                                                  input logic [3:0] n);
        logic [63:0] res;
        logic [3:0]  pos;
        logic [2:0]  dst;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            pos = {1'b0, lo} + 4'(i);
            dst = 3'(n - 4'(i) - 4'd1);
            if (4'(i) < n)
            begin
                res[dst*8 +: 8] = win[pos*8 +: 8];
            end
        end
        return res;
    endfunction

    logic                op_reg;
    logic [15:0]         addr_reg;
    logic [3:0]          len_reg;
    logic [63:0]         data_reg;
    logic                wt_reg;
    logic [WAYS-1:0]     valid_reg [salc_pkg::SETS];
    logic                hit_reg, alloc_reg, wb_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [TAG_W-1:0]    vtag_reg;
    logic [127:0]        cwin_reg, mwin_reg;
    logic                done_reg, was_store_reg, hit_out_reg;
    logic [15:0]         echo_reg;
    logic [63:0]         load_reg;

    logic [SET_W-1:0]    set_idx;
    logic [TAG_W-1:0]    tag_in;
    logic [2:0]          lo;
    logic [WORD_W-1:0]   w0, w1, fill_prev;
    logic [WAYS-1:0]     cur_valid;

    logic [salc_pkg::SET_ENTRY_W-1:0] tag_rdata, tag_wdata;
    logic                tag_we;
    logic [TAG_W-1:0]    tags  [WAYS];
    logic [RANK_W-1:0]   ranks [WAYS];

    logic                hit_c, inv_found;
    logic [WAY_W-1:0]    hit_way, inv_way, lru_way, vic_way, way_c;
    logic [RANK_W:0]     old_rank;
    logic                alloc_c;

    logic [salc_pkg::LINE_AW-1:0] c_raddr, c_waddr;
    logic [63:0]         c_wdata, c_rdata;
    logic                c_we;
    logic [salc_pkg::MEM_AW-1:0]  m_raddr, m_waddr;
    logic [63:0]         m_wdata, m_rdata;
    logic                m_we;
    logic [127:0]        cwin_new, mwin_new;
    logic                fill_wr;

    assign set_idx   = addr_reg[OFF_W +: SET_W];
    assign tag_in    = addr_reg[15 -: TAG_W];
    assign lo        = addr_reg[2:0];
    assign w0        = addr_reg[OFF_W-1:3];
    assign w1        = w0 + 1'b1;
    assign fill_prev = cmd.fill_cnt[WORD_W-1:0] - 1'b1;
    assign fill_wr   = cmd.fill && (cmd.fill_cnt != '0);
    assign cur_valid = valid_reg[set_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int s = 0; s < salc_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            if (write_through_we)
            begin
                wt_reg <= write_through;
            end
            done_reg <= cmd.wr1;
            if (tag_we)
            begin
                valid_reg[set_idx][way_c] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= operation;
            addr_reg <= byte_address;
            len_reg  <= (access_bytes > 4'd8) ? 4'd8 : access_bytes;
            data_reg <= store_data;
        end
        if (cmd.cmp)
        begin
            hit_reg   <= hit_c;
            alloc_reg <= alloc_c;
            way_reg   <= way_c;
            wb_reg    <= alloc_c && cur_valid[vic_way] && !wt_reg;
            vtag_reg  <= tags[vic_way];
        end
        if (cmd.rd1)
        begin
            cwin_reg[63:0] <= c_rdata;
            mwin_reg[63:0] <= m_rdata;
        end
        if (cmd.cap)
        begin
            cwin_reg[127:64] <= c_rdata;
            mwin_reg[127:64] <= m_rdata;
        end
        if (cmd.wr1)
        begin
            was_store_reg <= op_reg;
            echo_reg      <= addr_reg;
            hit_out_reg   <= hit_reg;
            load_reg      <= op_reg ? 64'd0 : extract_bytes(cwin_reg, lo, len_reg);
        end
    end

    // Lookup, victim choice and rank update for the addressed set.
    always_comb
    begin
        hit_c     = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        lru_way   = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            tags[i]  = tag_rdata[i*ENT_W +: TAG_W];
            ranks[i] = tag_rdata[i*ENT_W + TAG_W +: RANK_W];
        end
        for (int i = 0; i < WAYS; i++)
        begin
            if (cur_valid[i] && (tags[i] == tag_in) && !hit_c)
            begin
                hit_c   = 1'b1;
                hit_way = WAY_W'(i);
            end
            if (!cur_valid[i] && !inv_found)
            begin
                inv_found = 1'b1;
                inv_way   = WAY_W'(i);
            end
        end
        for (int i = 1; i < WAYS; i++)
        begin
            if (ranks[i] > ranks[lru_way])
            begin
                lru_way = WAY_W'(i);
            end
        end
        vic_way  = inv_found ? inv_way : lru_way;
        alloc_c  = !hit_c && !(op_reg && wt_reg);
        way_c    = hit_c ? hit_way : vic_way;
        old_rank = cur_valid[way_c] ? {1'b0, ranks[way_c]} : (RANK_W + 1)'(WAYS);
        tag_we   = cmd.cmp && (hit_c || alloc_c);
        tag_wdata = tag_rdata;
        for (int j = 0; j < WAYS; j++)
        begin
            if (WAY_W'(j) == way_c)
            begin
                tag_wdata[j*ENT_W +: ENT_W] = {RANK_W'(0), tag_in};
            end
            else if (cur_valid[j] && ({1'b0, ranks[j]} < old_rank))
            begin
                tag_wdata[j*ENT_W + TAG_W +: RANK_W] = ranks[j] + 1'b1;
            end
        end
    end

    assign status.alloc = alloc_c;
    assign status.hit   = hit_c;

    assign cwin_new = merge_bytes(cwin_reg, lo, len_reg, data_reg);
    assign mwin_new = merge_bytes(mwin_reg, lo, len_reg, data_reg);

    // Block transfer streams one word a cycle; each word is written in the cycle after it is read.
    always_comb
    begin
        c_raddr = {set_idx, way_reg, w0};
        c_waddr = {set_idx, way_reg, w0};
        c_wdata = cwin_new[63:0];
        c_we    = 1'b0;
        m_raddr = {addr_reg[15:OFF_W], w0};
        m_waddr = {addr_reg[15:OFF_W], w0};
        m_wdata = mwin_new[63:0];
        m_we    = 1'b0;
        if (cmd.clear)
        begin
            m_waddr = cmd.clr_addr;
            m_wdata = '0;
            m_we    = 1'b1;
        end
        else if (cmd.fill)
        begin
            c_raddr = {set_idx, way_reg, cmd.fill_cnt[WORD_W-1:0]};
            m_raddr = {addr_reg[15:OFF_W], cmd.fill_cnt[WORD_W-1:0]};
            c_waddr = {set_idx, way_reg, fill_prev};
            c_wdata = m_rdata;
            c_we    = fill_wr;
            m_waddr = {vtag_reg, set_idx, fill_prev};
            m_wdata = c_rdata;
            m_we    = fill_wr && wb_reg;
        end
        else if (cmd.rd1)
        begin
            c_raddr = {set_idx, way_reg, w1};
            m_raddr = {addr_reg[15:OFF_W], w1};
        end
        else if (cmd.wr0)
        begin
            c_we = op_reg && (hit_reg || alloc_reg);
            m_we = op_reg && wt_reg;
        end
        else if (cmd.wr1)
        begin
            c_waddr = {set_idx, way_reg, w1};
            c_wdata = cwin_new[127:64];
            c_we    = op_reg && (hit_reg || alloc_reg);
            m_waddr = {addr_reg[15:OFF_W], w1};
            m_wdata = mwin_new[127:64];
            m_we    = op_reg && wt_reg;
        end
    end

    salc_ram #(
        .WIDTH (salc_pkg::SET_ENTRY_W),
        .DEPTH (salc_pkg::SETS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (set_idx),
        .wdata (tag_wdata),
        .raddr (set_idx),
        .rdata (tag_rdata)
    );

    salc_ram #(
        .WIDTH (64),
        .DEPTH (salc_pkg::LINE_WORDS)
    ) u_line_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    salc_ram #(
        .WIDTH (64),
        .DEPTH (salc_pkg::MEM_WORDS)
    ) u_mem_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign done         = done_reg;
    assign was_store    = was_store_reg;
    assign echo_address = echo_reg;
    assign hit          = hit_out_reg;
    assign load_data    = load_reg;

endmodule

// ===== rtl/core/set_assoc_lru_cache_unit.sv =====
// Top level of the 4-way set-associative LRU cache unit with its backing memory.
//
//  Channel   Handshake                  Words
//  input     start, busy (accept when   operation, byte_address, access_bytes,
//            start high and busy low)   store_data
//  result    done (one-cycle strobe)    was_store, echo_address, hit, load_data
//  config    write_through_we           write_through
//
// A hit passes the tag, compare, read, capture and write states; a miss that
// allocates also fills, moving the block through the 64-bit line and memory
// RAMs one word per cycle. After reset the unit clears all 8192 memory words
// with busy high. The receiver cannot stall; busy falls as done is shown.
`timescale 1ns / 1ps
module set_assoc_lru_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        write_through_we,
    input  logic        write_through,
    input  logic        operation,
    input  logic [15:0] byte_address,
    input  logic [3:0]  access_bytes,
    input  logic [63:0] store_data,
    output logic        done,
    output logic        was_store,
    output logic [15:0] echo_address,
    output logic        hit,
    output logic [63:0] load_data
);

    salc_pkg::cmd_t    cmd;
    salc_pkg::status_t status;

    salc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    salc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .write_through_we (write_through_we),
        .write_through    (write_through),
        .operation        (operation),
        .byte_address     (byte_address),
        .access_bytes     (access_bytes),
        .store_data       (store_data),
        .done             (done),
        .was_store        (was_store),
        .echo_address     (echo_address),
        .hit              (hit),
        .load_data        (load_data)
    );

    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.cmp, cmd.fill, cmd.rd0, cmd.rd1, cmd.cap, cmd.wr0, cmd.wr1}))
        else $error("more than one datapath phase active");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted word");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside the end of an item");

    a_fill_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cmp && status.alloc) |-> !status.hit)
        else $error("allocation requested on a hit");

endmodule
